// ===== rtl/scc_pkg.sv =====
// Package: shared constants and types for the sector cache clock controller.
package scc_pkg;
   localparam int DEF_ENTRIES      = 64;
   localparam int DEF_SECTOR_BYTES = 512;
   localparam int MAX_FLUSH        = 64;
   localparam int CMD_W            = 2;
   localparam int SECTOR_W         = 32;
   localparam int OFFSET_W         = 9;
   localparam int LENGTH_W         = 10;
   localparam int SLOT_W           = 6;
   localparam int ADDR_W           = 15;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;
endpackage

// ===== rtl/sector_cache_clock_controller.sv =====
// Sector cache clock controller: tag memory, lookup, clock sweep and flush scan.
//
// One word is taken per start pulse while busy is low. The tag store is a
// synchronous memory read one slot per cycle, so a read or write takes a
// lookup scan over all ENTRIES slots plus up to 2*ENTRIES+1 steps of the
// clock hand on a miss (one memory read per step); a flush scans the slots
// until all are seen or MAX_FLUSH dirty slots are found. Results come out as
// one-cycle strobes on rsp_valid and must be taken at once; rsp_last marks the
// final result of a command. Valid, dirty and accessed flags sit in flip-flops
// cleared by reset, so no clearing pass is needed after reset.
module sector_cache_clock_controller
   import scc_pkg::*;
#(
   parameter int ENTRIES      = DEF_ENTRIES,
   parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [OFFSET_W-1:0] req_offset,
   input  logic [LENGTH_W-1:0] req_length,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_writeback_needed,
   output logic [SECTOR_W-1:0] rsp_writeback_sector,
   output logic                rsp_fill_needed,
   output logic [ADDR_W-1:0]   rsp_data_address,
   output logic [LENGTH_W-1:0] rsp_data_length,
   output logic                rsp_last
);
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int SWP_W  = $clog2(2 * ENTRIES + 2);
   localparam int FLW_W  = $clog2(MAX_FLUSH + 1);
   localparam int SB_W   = $clog2(SECTOR_BYTES);
   localparam int OFFMAX = SECTOR_BYTES - 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_SWEEP, ST_SWEEP_CHK, ST_FLUSH, ST_FLUSH_CHK
   } state_type;

   logic [SECTOR_W-1:0] tag_mem [ENTRIES];
   logic [SECTOR_W-1:0] tag_rd_ff;
   logic                tag_we;
   logic [IDX_W-1:0]    tag_waddr;
   logic [IDX_W-1:0]    tag_raddr;

   logic [ENTRIES-1:0]  valid_ff, dirty_ff, acc_ff;
   logic [IDX_W-1:0]    hand_ff;
   state_type           state_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [SECTOR_W-1:0] sector_ff;
   logic [SB_W:0]       off_ff;
   logic [LENGTH_W-1:0] len_ff;
   logic [CNT_W-1:0]    scan_ff;
   logic [IDX_W-1:0]    ridx_ff;
   logic                rpend_ff;
   logic [SWP_W-1:0]    swp_ff;
   logic [FLW_W-1:0]    nfl_ff;
   logic                have_ff;
   logic [IDX_W-1:0]    held_ff;
   logic [SECTOR_W-1:0] held_tag_ff;

   logic [SB_W:0] off_c, len_lim;
   logic [LENGTH_W-1:0] len_c;
   logic [SB_W:0] req_off_w;

   always_comb begin
      req_off_w = (SB_W + 1)'(req_offset);
      off_c = (32'(req_offset) > OFFMAX) ? (SB_W + 1)'(OFFMAX) : req_off_w;
      len_lim = (SB_W + 1)'(SECTOR_BYTES) - off_c;
      len_c = (32'(req_length) > 32'(len_lim)) ? LENGTH_W'(len_lim) : req_length;
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[tag_waddr] <= sector_ff;
      tag_rd_ff <= tag_mem[tag_raddr];
   end

   function automatic logic [ADDR_W-1:0] addr_of(logic [IDX_W-1:0] s, logic [SB_W:0] o);
      logic [ADDR_W+SB_W+IDX_W:0] a;
      a = (ADDR_W+SB_W+IDX_W+1)'(s) * (ADDR_W+SB_W+IDX_W+1)'(SECTOR_BYTES)
          + (ADDR_W+SB_W+IDX_W+1)'(o);
      return a[ADDR_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] inc(logic [IDX_W-1:0] s);
      return (32'(s) == ENTRIES - 1) ? '0 : s + IDX_W'(1);
   endfunction

   // read address: whatever the state machine is about to look at
   always_comb begin
      tag_raddr = scan_ff[IDX_W-1:0];
      if (state_ff == ST_SWEEP || state_ff == ST_SWEEP_CHK) tag_raddr = hand_ff;
   end

   logic last_scan;
   assign last_scan = (32'(scan_ff) == ENTRIES);
   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      tag_we <= 1'b0;
      rsp_valid <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         dirty_ff <= '0;
         acc_ff   <= '0;
         hand_ff  <= '0;
         rpend_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff <= req_cmd;
                  sector_ff <= req_sector;
                  off_ff <= off_c;
                  len_ff <= len_c;
                  scan_ff <= '0;
                  rpend_ff <= 1'b0;
                  nfl_ff <= '0;
                  have_ff <= 1'b0;
                  case (cmd_type'(req_cmd))
                     CMD_READ, CMD_WRITE: state_ff <= ST_LOOK;
                     CMD_FLUSH: state_ff <= ST_FLUSH;
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            // address scan_ff issued this cycle; compare previous read
            ST_LOOK: begin
               rpend_ff <= !last_scan;
               ridx_ff <= scan_ff[IDX_W-1:0];
               if (!last_scan) scan_ff <= scan_ff + CNT_W'(1);
               if (rpend_ff && valid_ff[ridx_ff] && tag_rd_ff == sector_ff) begin
                  acc_ff[ridx_ff] <= 1'b1;
                  if (cmd_ff == CMD_WRITE) dirty_ff[ridx_ff] <= 1'b1;
                  rsp_valid <= 1'b1;
                  rsp_hit <= 1'b1;
                  rsp_slot <= SLOT_W'(ridx_ff);
                  rsp_writeback_needed <= 1'b0;
                  rsp_writeback_sector <= '0;
                  rsp_fill_needed <= 1'b0;
                  rsp_data_address <= addr_of(ridx_ff, off_ff);
                  rsp_data_length <= len_ff;
                  rsp_last <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (!rpend_ff && last_scan) begin
                  swp_ff <= '0;
                  state_ff <= ST_SWEEP;
               end
            end
            ST_SWEEP: state_ff <= ST_SWEEP_CHK; // tag of hand slot on read port
            ST_SWEEP_CHK: begin
               hand_ff <= inc(hand_ff);
               swp_ff <= swp_ff + SWP_W'(1);
               if (!valid_ff[hand_ff] || !acc_ff[hand_ff]
                   || 32'(swp_ff) == 2 * ENTRIES) begin
                  logic [IDX_W-1:0] s;
                  logic wb;
                  s = (32'(swp_ff) == 2 * ENTRIES && valid_ff[hand_ff] && acc_ff[hand_ff])
                      ? '0 : hand_ff;
                  wb = valid_ff[s] && !acc_ff[s] && dirty_ff[s] && s == hand_ff;
                  tag_we <= 1'b1;
                  tag_waddr <= s;
                  valid_ff[s] <= 1'b1;
                  acc_ff[s] <= 1'b1;
                  dirty_ff[s] <= (cmd_ff == CMD_WRITE);
                  rsp_valid <= 1'b1;
                  rsp_hit <= 1'b0;
                  rsp_slot <= SLOT_W'(s);
                  rsp_writeback_needed <= wb;
                  rsp_writeback_sector <= wb ? tag_rd_ff : '0;
                  rsp_fill_needed <= 1'b1;
                  rsp_data_address <= addr_of(s, off_ff);
                  rsp_data_length <= len_ff;
                  rsp_last <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  acc_ff[hand_ff] <= 1'b0;
                  state_ff <= ST_SWEEP;
               end
            end
            // flush: one dirty slot is held back so the final one can carry last
            ST_FLUSH: begin
               if (last_scan || 32'(nfl_ff) == MAX_FLUSH) begin
                  if (have_ff) begin
                     rsp_valid <= 1'b1;
                     rsp_hit <= 1'b0;
                     rsp_slot <= SLOT_W'(held_ff);
                     rsp_writeback_needed <= 1'b1;
                     rsp_writeback_sector <= held_tag_ff;
                     rsp_fill_needed <= 1'b0;
                     rsp_data_address <= addr_of(held_ff, '0);
                     rsp_data_length <= '0;
                     rsp_last <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end else begin
                  ridx_ff <= scan_ff[IDX_W-1:0];
                  scan_ff <= scan_ff + CNT_W'(1);
                  state_ff <= ST_FLUSH_CHK;
               end
            end
            ST_FLUSH_CHK: begin
               if (valid_ff[ridx_ff] && dirty_ff[ridx_ff]) begin
                  dirty_ff[ridx_ff] <= 1'b0;
                  nfl_ff <= nfl_ff + FLW_W'(1);
                  if (have_ff) begin
                     rsp_valid <= 1'b1;
                     rsp_hit <= 1'b0;
                     rsp_slot <= SLOT_W'(held_ff);
                     rsp_writeback_needed <= 1'b1;
                     rsp_writeback_sector <= held_tag_ff;
                     rsp_fill_needed <= 1'b0;
                     rsp_data_address <= addr_of(held_ff, '0);
                     rsp_data_length <= '0;
                     rsp_last <= 1'b0;
                  end
                  have_ff <= 1'b1;
                  held_ff <= ridx_ff;
                  held_tag_ff <= tag_rd_ff;
               end
               state_ff <= ST_FLUSH;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && (rsp_fill_needed || rsp_writeback_needed)))
      else $error("hit result carries fill or write-back");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy during final result");
   assert property (@(posedge clock) disable iff (reset)
      32'(hand_ff) < ENTRIES)
      else $error("clock hand out of range");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result in the cycle after accept");
endmodule

// ===== bench/sector_cache_clock_controller_tb.sv =====
// Testbench for the sector cache clock controller: directed table, fill and flush run, then random words.
`timescale 1ns / 100ps
module sector_cache_clock_controller_tb;
   import scc_pkg::*;

   localparam int NSLOT = DEF_ENTRIES;
   localparam int SBYTES = DEF_SECTOR_BYTES;
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 4 * NSLOT + 20;

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic                wb;
      logic [SECTOR_W-1:0] wb_sector;
      logic                fill;
      logic [ADDR_W-1:0]   addr;
      logic [LENGTH_W-1:0] len;
      logic                last;
   } cache_rsp_type;

   typedef struct {
      cmd_type             cmd;
      logic [SECTOR_W-1:0] sector;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      bit                  typed;   // row carries a hand-written expectation
      cache_rsp_type       rsp;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [CMD_W-1:0] req_cmd = CMD_READ;
   logic [SECTOR_W-1:0] req_sector = '0;
   logic [OFFSET_W-1:0] req_offset = '0;
   logic [LENGTH_W-1:0] req_length = '0;
   logic rsp_valid, rsp_hit, rsp_writeback_needed, rsp_fill_needed, rsp_last;
   logic [SLOT_W-1:0] rsp_slot;
   logic [SECTOR_W-1:0] rsp_writeback_sector;
   logic [ADDR_W-1:0] rsp_data_address;
   logic [LENGTH_W-1:0] rsp_data_length;

   sector_cache_clock_controller DUT (.*);

   always #5 clock = ~clock;

   // shadow cache state
   logic [SECTOR_W-1:0] tags [NSLOT];
   bit valid_q [NSLOT];
   bit dirty_q [NSLOT];
   bit used_q [NSLOT];
   int hand;

   cache_rsp_type pending_rsps [$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 0;   // no input gaps during this stretch
   logic [SECTOR_W-1:0] hot_sectors [16];

   function automatic cache_rsp_type mk_rsp(int h, int s, int w, logic [31:0] ws,
                                            int f, int a, int l, int lst);
      cache_rsp_type r;
      r.hit = h[0]; r.slot = SLOT_W'(s); r.wb = w[0]; r.wb_sector = ws; r.fill = f[0];
      r.addr = ADDR_W'(a); r.len = LENGTH_W'(l); r.last = lst[0];
      return r;
   endfunction

   // compute results of one word and update the shadow state
   task automatic predict_access(cmd_type cmd, logic [31:0] sector, int off_in, int len_in);
      int off, len, s, n;
      bit found, wb;
      logic [31:0] wbs;
      cache_rsp_type r;
      off = off_in; len = len_in; s = 0; n = 0; found = 0; wb = 0; wbs = 0;
      if (cmd == CMD_FLUSH) begin
         for (int i = 0; i < NSLOT && n < MAX_FLUSH; i++) begin
            if (valid_q[i] && dirty_q[i]) begin
               dirty_q[i] = 0;
               pending_rsps.push_back(mk_rsp(0, i, 1, tags[i], 0, i * SBYTES, 0, 0));
               n++;
            end
         end
         if (n > 0) begin
            r = pending_rsps.pop_back();
            r.last = 1'b1;
            pending_rsps.push_back(r);
         end
         return;
      end
      if (cmd == CMD_NONE) return;
      if (off > SBYTES - 1) off = SBYTES - 1;
      if (len > SBYTES - off) len = SBYTES - off;
      for (int i = 0; i < NSLOT; i++) begin
         if (!found && valid_q[i] && tags[i] == sector) begin
            s = i; found = 1;
         end
      end
      if (!found) begin
         for (int k = 0; k < 2 * NSLOT + 1; k++) begin
            s = hand;
            hand = (hand + 1) % NSLOT;
            if (!valid_q[s]) break;
            if (!used_q[s]) begin
               if (dirty_q[s]) begin
                  wb = 1; wbs = tags[s]; dirty_q[s] = 0;
               end
               valid_q[s] = 0;
               break;
            end
            used_q[s] = 0;
         end
         tags[s] = sector; valid_q[s] = 1; dirty_q[s] = 0;
      end
      used_q[s] = 1;
      if (cmd == CMD_WRITE) dirty_q[s] = 1;
      pending_rsps.push_back(mk_rsp(found, s, wb, wbs, !found, s * SBYTES + off, len, 1));
   endtask

   task automatic send_word(cmd_type cmd, logic [31:0] sector, int off, int len);
      while (!quiet && $urandom_range(99) < 23) @(posedge clock);
      start <= 1;
      req_cmd <= cmd;
      req_sector <= sector;
      req_offset <= OFFSET_W'(off);
      req_length <= LENGTH_W'(len);
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 0;
      // let the word register before busy is sampled again
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      cache_rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            $error("unexpected result word at slot %0d", rsp_slot);
            errors++;
         end else begin
            e = pending_rsps.pop_front();
            check_field("hit", 32'(e.hit), 32'(rsp_hit));
            check_field("slot", 32'(e.slot), 32'(rsp_slot));
            check_field("writeback_needed", 32'(e.wb), 32'(rsp_writeback_needed));
            check_field("writeback_sector", e.wb_sector, rsp_writeback_sector);
            check_field("fill_needed", 32'(e.fill), 32'(rsp_fill_needed));
            check_field("data_address", 32'(e.addr), 32'(rsp_data_address));
            check_field("data_length", 32'(e.len), 32'(rsp_data_length));
            check_field("last", 32'(e.last), 32'(rsp_last));
         end
      end
   end

   // watchdog: cycles with nothing accepted and no result
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   dir_row_type dir_rows [$];

   task automatic add_row(cmd_type c, logic [31:0] s, int o, int l, bit t = 0,
                          cache_rsp_type r = '0);
      dir_row_type d;
      d.cmd = c; d.sector = s; d.offset = OFFSET_W'(o); d.length = LENGTH_W'(l);
      d.typed = t; d.rsp = r;
      dir_rows.push_back(d);
   endtask

   initial begin
      cmd_type c;
      int pick;
      int len_pick;
      logic [31:0] sec;
      for (int i = 0; i < NSLOT; i++) begin
         tags[i] = '1; valid_q[i] = 0; dirty_q[i] = 0; used_q[i] = 0;
      end
      hand = 0;
      for (int i = 0; i < 16; i++) hot_sectors[i] = $urandom;
      hot_sectors[0] = '1;
      hot_sectors[1] = '0;

      // directed table
      add_row(CMD_FLUSH, 0, 0, 0);                               // nothing dirty
      add_row(CMD_READ, 32'hFFFF_FFFF, 0, 512, 1, mk_rsp(0, 0, 0, 0, 1, 0, 512, 1));
      add_row(CMD_READ, 32'hFFFF_FFFF, 511, 512, 1, mk_rsp(1, 0, 0, 0, 0, 511, 1, 1));
      add_row(CMD_WRITE, 0, 0, 512, 1, mk_rsp(0, 1, 0, 0, 1, 512, 512, 1));
      add_row(CMD_NONE, 5, 3, 3);                                // ignored
      add_row(CMD_WRITE, 32'h1234_5678, 100, 1023);              // length clamp
      add_row(CMD_READ, 7, 0, 0);
      add_row(CMD_WRITE, 32'hFFFF_FFFF, 256, 300);
      add_row(CMD_FLUSH, 0, 0, 0);
      add_row(CMD_FLUSH, 0, 0, 0);
      add_row(CMD_WRITE, 32'hAAAA_5555, 0, 0);
      add_row(CMD_READ, 32'h5555_AAAA, 511, 0);

      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].typed) begin
            predict_access(dir_rows[i].cmd, dir_rows[i].sector,
                           dir_rows[i].offset, dir_rows[i].length);
            void'(pending_rsps.pop_back());
            pending_rsps.push_back(dir_rows[i].rsp);
         end else begin
            predict_access(dir_rows[i].cmd, dir_rows[i].sector,
                           dir_rows[i].offset, dir_rows[i].length);
         end
         send_word(dir_rows[i].cmd, dir_rows[i].sector, dir_rows[i].offset,
                   dir_rows[i].length);
      end

      // fill every slot dirty, force evictions with write-back, then a full flush
      for (int i = 0; i < NSLOT + 8; i++) begin
         sec = 32'h8000_0000 + i;
         predict_access(CMD_WRITE, sec, i, 512 - i);
         send_word(CMD_WRITE, sec, i, 512 - i);
      end
      predict_access(CMD_FLUSH, 0, 0, 0);
      send_word(CMD_FLUSH, 0, 0, 0);

      // random part; a stretch in the middle runs without gaps
      for (int n = 0; n < 36; n++) begin
         quiet = (n >= 12 && n < 26);
         pick = $urandom_range(99);
         if (pick < 45) c = CMD_READ;
         else if (pick < 88) c = CMD_WRITE;
         else if (pick < 96) c = CMD_FLUSH;
         else c = CMD_NONE;
         sec = ($urandom_range(99) < 60) ? hot_sectors[$urandom_range(15)] : $urandom;
         pick = $urandom_range(1023);
         len_pick = $urandom_range(1023);
         predict_access(c, sec, pick[8:0], len_pick);
         send_word(c, sec, pick[8:0], len_pick);
      end
      quiet = 0;

      while (pending_rsps.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
